@@ rtl/stake_bracket_weight_select_unit_assert.svh @@
// Assertion macros used by the checker module.
`ifndef STAKE_BRACKET_WEIGHT_SELECT_UNIT_ASSERT_SVH
`define STAKE_BRACKET_WEIGHT_SELECT_UNIT_ASSERT_SVH

// same-cycle implication
`define SBWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbws_pkg.sv @@
package sbws_pkg;

  localparam int NUM_BRACKETS_DEF = 13;
  localparam int VALUE_W  = 63;
  localparam int WORD_W   = 64;
  localparam int WIDE_W   = 4 * WORD_W;
  localparam int BRK_W    = 4;
  localparam int BMIN_W   = 61;
  localparam int WEIGHT_W = 49;
  localparam int DIGIT_W  = 16;
  localparam int NUM_DIGITS = WIDE_W / DIGIT_W;
  localparam int CNT_W    = $clog2(NUM_DIGITS);
  localparam int ACC_W    = DIGIT_W + WEIGHT_W;
  localparam logic [VALUE_W-1:0] MIN_ELIGIBLE = VALUE_W'(16);

  typedef struct packed {
    logic en;
    logic first;
  } mac_ctl_t;

  typedef struct packed {
    logic ovf;
    logic ge;
  } mac_stat_t;

  function automatic logic [WEIGHT_W-1:0] weight(input logic [BRK_W-1:0] b);
    logic [WEIGHT_W-1:0] w;
    case (b)
      4'd0:    w = WEIGHT_W'(0);
      4'd1:    w = WEIGHT_W'(64'd17);
      4'd2:    w = WEIGHT_W'(64'd257);
      4'd3:    w = WEIGHT_W'(64'd4097);
      4'd4:    w = WEIGHT_W'(64'd65537);
      4'd5:    w = WEIGHT_W'(64'd1048577);
      4'd6:    w = WEIGHT_W'(64'd16777217);
      4'd7:    w = WEIGHT_W'(64'd268435457);
      4'd8:    w = WEIGHT_W'(64'd4080218932);
      4'd9:    w = WEIGHT_W'(64'd62534723830);
      4'd10:   w = WEIGHT_W'(64'd780653255721);
      4'd11:   w = WEIGHT_W'(64'd8796093022208);
      4'd12:   w = WEIGHT_W'(64'd84442493013197);
      default: w = WEIGHT_W'(64'd450359962737049);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/sbws_mac.sv @@
module sbws_mac (
  input  logic                             clk,
  input  sbws_pkg::mac_ctl_t               ctl,
  input  logic [sbws_pkg::DIGIT_W-1:0]     tgt_digit,
  input  logic [sbws_pkg::DIGIT_W-1:0]     prf_digit,
  input  logic [sbws_pkg::WEIGHT_W-1:0]    wgt,
  output sbws_pkg::mac_stat_t              stat
);

  logic [sbws_pkg::WEIGHT_W-1:0] carry_r;
  logic                          ge_r;
  logic [sbws_pkg::WEIGHT_W-1:0] cin;
  logic [sbws_pkg::ACC_W-1:0]    acc;
  logic [sbws_pkg::DIGIT_W-1:0]  pdig;
  logic                          ge_prev;
  logic                          ge_nxt;

  assign cin     = ctl.first ? '0 : carry_r;
  assign acc     = sbws_pkg::ACC_W'(tgt_digit) * sbws_pkg::ACC_W'(wgt)
                 + sbws_pkg::ACC_W'(cin);
  assign pdig    = acc[sbws_pkg::DIGIT_W-1:0];
  assign ge_prev = ctl.first ? 1'b1 : ge_r;
  // higher digits decide, so a differing digit overrides what came below
  assign ge_nxt  = (pdig != prf_digit) ? (prf_digit > pdig) : ge_prev;

  assign stat.ge  = ge_nxt;
  assign stat.ovf = |acc[sbws_pkg::ACC_W-1:sbws_pkg::DIGIT_W];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      carry_r <= acc[sbws_pkg::ACC_W-1:sbws_pkg::DIGIT_W];
      ge_r    <= ge_nxt;
    end
  end

endmodule

@@ rtl/stake_bracket_weight_select_unit.sv @@
// Ineligible values and clamped bracket <= 1 go straight from accept to the result;
// otherwise k brackets are scanned first, k = 1 .. NUM_BRACKETS-1, from the top down.
// Items are taken one at a time; the 16x49 multiplier takes one 16-bit digit
// of the 256-bit target per cycle, so each scanned bracket is a full pass of the digits.
// A new item is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) empties the block; no item or result survives.
module stake_bracket_weight_select_unit #(
  parameter int NUM_BRACKETS = sbws_pkg::NUM_BRACKETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sbws_pkg::VALUE_W-1:0]    in_coin_value,
  input  logic [sbws_pkg::WORD_W-1:0]     in_target_w0,
  input  logic [sbws_pkg::WORD_W-1:0]     in_target_w1,
  input  logic [sbws_pkg::WORD_W-1:0]     in_target_w2,
  input  logic [sbws_pkg::WORD_W-1:0]     in_target_w3,
  input  logic [sbws_pkg::WORD_W-1:0]     in_proof_w0,
  input  logic [sbws_pkg::WORD_W-1:0]     in_proof_w1,
  input  logic [sbws_pkg::WORD_W-1:0]     in_proof_w2,
  input  logic [sbws_pkg::WORD_W-1:0]     in_proof_w3,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_eligible,
  output logic [sbws_pkg::BRK_W-1:0]      out_bracket_index,
  output logic [sbws_pkg::BMIN_W-1:0]     out_bracket_minimum,
  output logic [sbws_pkg::WEIGHT_W-1:0]   out_table_weight,
  output logic [sbws_pkg::WEIGHT_W-1:0]   out_found_weight
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  localparam int NIBS = sbws_pkg::WORD_W / 4;

  state_t                         state_r;
  logic                           out_valid_r;
  logic                           elig_r;
  logic [sbws_pkg::BRK_W-1:0]     brk_r;
  logic [sbws_pkg::BMIN_W-1:0]    bmin_r;
  logic [sbws_pkg::WEIGHT_W-1:0]  tw_r;
  logic [sbws_pkg::WEIGHT_W-1:0]  found_r;
  logic [sbws_pkg::BRK_W-1:0]     b_r;
  logic [sbws_pkg::CNT_W-1:0]     cnt_r;
  logic [sbws_pkg::WIDE_W-1:0]    tgt_r;
  logic [sbws_pkg::WIDE_W-1:0]    prf_r;
  logic                           out_elig_r;
  logic [sbws_pkg::BRK_W-1:0]     out_brk_r;
  logic [sbws_pkg::BMIN_W-1:0]    out_bmin_r;
  logic [sbws_pkg::WEIGHT_W-1:0]  out_tw_r;
  logic [sbws_pkg::WEIGHT_W-1:0]  out_found_r;

  logic                           in_fire;
  logic                           elig;
  logic [sbws_pkg::VALUE_W-1:0]   vm1;
  logic [sbws_pkg::WORD_W-1:0]    vm1_ext;
  logic [sbws_pkg::BRK_W-1:0]     top_nib;
  logic [sbws_pkg::BRK_W-1:0]     brk;
  logic [sbws_pkg::BRK_W-1:0]     clamp;
  logic                           last_digit;
  sbws_pkg::mac_ctl_t             mac_ctl;
  sbws_pkg::mac_stat_t            mac_stat;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign elig    = in_coin_value > sbws_pkg::MIN_ELIGIBLE;
  assign vm1     = in_coin_value - sbws_pkg::VALUE_W'(1);
  assign vm1_ext = sbws_pkg::WORD_W'(vm1);

  always_comb begin
    top_nib = '0;
    for (int k = 0; k < NIBS; k++) begin
      if (|vm1_ext[4*k +: 4]) top_nib = sbws_pkg::BRK_W'(k);
    end
  end

  // bracket is the index of the nibble that holds the leading one
  assign brk   = top_nib;
  assign clamp = (brk > sbws_pkg::BRK_W'(NUM_BRACKETS)) ? sbws_pkg::BRK_W'(NUM_BRACKETS) : brk;

  assign last_digit    = (cnt_r == sbws_pkg::CNT_W'(sbws_pkg::NUM_DIGITS - 1));
  assign mac_ctl.en    = (state_r == S_SCAN);
  assign mac_ctl.first = (cnt_r == '0);

  sbws_mac u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .tgt_digit (tgt_r[sbws_pkg::DIGIT_W-1:0]),
    .prf_digit (prf_r[sbws_pkg::DIGIT_W-1:0]),
    .wgt       (sbws_pkg::weight(b_r)),
    .stat      (mac_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            tgt_r  <= {in_target_w3, in_target_w2, in_target_w1, in_target_w0};
            prf_r  <= {in_proof_w3, in_proof_w2, in_proof_w1, in_proof_w0};
            cnt_r  <= '0;
            b_r    <= clamp - sbws_pkg::BRK_W'(1);
            elig_r <= elig;
            if (!elig) begin
              brk_r   <= '0;
              bmin_r  <= '0;
              tw_r    <= '0;
              found_r <= '0;
              state_r <= S_DONE;
            end else begin
              brk_r  <= brk;
              bmin_r <= (sbws_pkg::BMIN_W'(1) << {brk, 2'b00}) + sbws_pkg::BMIN_W'(1);
              tw_r   <= sbws_pkg::weight(clamp);
              if (clamp <= sbws_pkg::BRK_W'(1)) begin
                found_r <= sbws_pkg::weight(sbws_pkg::BRK_W'(1));
                state_r <= S_DONE;
              end else begin
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          // rotate one digit so the words line up again after a full pass
          tgt_r <= {tgt_r[sbws_pkg::DIGIT_W-1:0], tgt_r[sbws_pkg::WIDE_W-1:sbws_pkg::DIGIT_W]};
          prf_r <= {prf_r[sbws_pkg::DIGIT_W-1:0], prf_r[sbws_pkg::WIDE_W-1:sbws_pkg::DIGIT_W]};
          cnt_r <= cnt_r + sbws_pkg::CNT_W'(1);
          if (last_digit) begin
            if (!mac_stat.ovf && mac_stat.ge) begin
              found_r <= sbws_pkg::weight(b_r + sbws_pkg::BRK_W'(1));
              state_r <= S_DONE;
            end else if (b_r == sbws_pkg::BRK_W'(1)) begin
              found_r <= sbws_pkg::weight(sbws_pkg::BRK_W'(1));
              state_r <= S_DONE;
            end else begin
              b_r <= b_r - sbws_pkg::BRK_W'(1);
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_elig_r  <= elig_r;
            out_brk_r   <= brk_r;
            out_bmin_r  <= bmin_r;
            out_tw_r    <= tw_r;
            out_found_r <= found_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_eligible        = out_elig_r;
  assign out_bracket_index   = out_brk_r;
  assign out_bracket_minimum = out_bmin_r;
  assign out_table_weight    = out_tw_r;
  assign out_found_weight    = out_found_r;

endmodule

@@ rtl/sbws_checker.sv @@
`include "stake_bracket_weight_select_unit_assert.svh"

module sbws_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_eligible,
  input logic [sbws_pkg::BRK_W-1:0]      out_bracket_index,
  input logic [sbws_pkg::BMIN_W-1:0]     out_bracket_minimum,
  input logic [sbws_pkg::WEIGHT_W-1:0]   out_table_weight,
  input logic [sbws_pkg::WEIGHT_W-1:0]   out_found_weight
);

  `SBWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_found_weight) && $stable(out_bracket_minimum), "stalled result beat changed")
  `SBWS_ASSERT_NOW(a_inelig_zero, out_valid && !out_eligible, out_bracket_index == '0 && out_bracket_minimum == '0 && out_table_weight == '0 && out_found_weight == '0, "ineligible beat carries nonzero fields")
  `SBWS_ASSERT_NOW(a_elig_found, out_valid && out_eligible, out_found_weight != '0, "eligible beat has zero found weight")
  `SBWS_ASSERT_NOW(a_elig_bmin, out_valid && out_eligible, out_bracket_minimum[0] == 1'b1, "bracket minimum not odd")

endmodule

bind stake_bracket_weight_select_unit sbws_checker u_sbws_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_eligible        (out_eligible),
  .out_bracket_index   (out_bracket_index),
  .out_bracket_minimum (out_bracket_minimum),
  .out_table_weight    (out_table_weight),
  .out_found_weight    (out_found_weight)
);
